// File: sv/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int FRAMES     = 128;
  localparam int PAGE_BYTES = 1000;
  localparam int JOBS       = 16;

  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int JOB_W     = 4;
  localparam int OWNER_W   = $clog2(JOBS + 1);
  localparam int BYTES_W   = 17;
  localparam int ADDR_W    = 17;
  localparam int OFF_W     = 10;
  localparam int STATUS_W  = 3;
  localparam int FRNUM_W   = 7;
  localparam int CHG_W     = 8;
  localparam int OP_W      = 2;

  // x / PAGE_BYTES == (x * RECIP) >> RECIP_SHIFT for every x below 2**DIVIDEND_W
  localparam int DIVIDEND_W  = BYTES_W + 1;
  localparam int RECIP_SHIFT = DIVIDEND_W + $clog2(PAGE_BYTES);
  localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = DIVIDEND_W + RECIP_W;
  localparam int Q_W         = CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_RECLAIM   = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FRAMES = 3'd1,
    ST_NO_JOB    = 3'd2,
    ST_BOUNDS    = 3'd3,
    ST_EXISTS    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_Q,
    S_MUL_R,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    logic [OWNER_W-1:0] owner;
  } tbl_wr_t;

endpackage

// File: sv/pfa_req_if.sv
`timescale 1ns / 1ps

interface pfa_req_if
  import pfa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [JOB_W-1:0]   job_id;
  logic [BYTES_W-1:0] byte_count;
  logic [ADDR_W-1:0]  logical_address;

  modport source (output valid, operation, job_id, byte_count, logical_address,
                  input ready);
  modport sink   (input valid, operation, job_id, byte_count, logical_address,
                  output ready);
endinterface

// File: sv/pfa_rsp_if.sv
`timescale 1ns / 1ps

interface pfa_rsp_if
  import pfa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRNUM_W-1:0]  frame_number;
  logic [OFF_W-1:0]    page_offset;
  logic [CHG_W-1:0]    frames_changed;
  logic [CHG_W-1:0]    free_frames;

  modport source (output valid, status, frame_number, page_offset, frames_changed,
                  free_frames, input ready);
  modport sink   (input valid, status, frame_number, page_offset, frames_changed,
                  free_frames, output ready);
endinterface

// File: sv/pfa_frame_table.sv
`timescale 1ns / 1ps

module pfa_frame_table
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  tbl_rd_t            rd,
  input  tbl_wr_t            wr,
  output logic [OWNER_W-1:0] rd_owner
);

  logic [OWNER_W-1:0] mem [FRAMES];
  logic [FRAMES-1:0]  written;
  logic [OWNER_W-1:0] rd_data;
  logic               rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.owner;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

  // never-written entries read as free
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_written <= written[rd.addr];
      end
    end
  end

  assign rd_owner = rd_written ? rd_data : '0;

endmodule

// File: sv/paged_frame_allocator_top.sv
`timescale 1ns / 1ps

// Paged frame allocator: allocate takes the lowest free frames for a job, reclaim
// frees all of a job's frames, translate maps a job's byte address to a frame and
// offset. One word is worked on at a time; req.ready is high only while idle, and a
// finished result sits in the output register so the next word can be taken while
// it waits. A word rejected by the job checks (job exists, job absent, address out
// of bounds, unused operation) goes from the checks straight to the done state.
// Reclaim starts its walk right after the checks; allocate and translate first go
// through the multiplier states S_MUL_Q and S_MUL_R, after which an allocate that
// grants nothing (too few frames, zero bytes) goes to the done state. The walk reads
// the frame table one entry per cycle through its single read port: allocate stops
// at its last granted frame, translate at the frame found or else at the last entry,
// and reclaim always walks all FRAMES entries. A result that cannot leave holds the
// block in its done state. Frame table contents need no clearing pass after reset.
module paged_frame_allocator_top
  import pfa_pkg::*;
(
  input logic      clk,
  input logic      rst,
  pfa_req_if.sink  req,
  pfa_rsp_if.source rsp
);

  state_t state, state_next;

  logic [OP_W-1:0]    op_r;
  logic [JOB_W-1:0]   id_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [ADDR_W-1:0]  addr_r;

  logic [BYTES_W-1:0] job_bytes [JOBS];
  logic [JOBS-1:0]    job_live;
  logic [CNT_W-1:0]   free_count;

  // shared multiplier
  logic [DIVIDEND_W-1:0] mul_a;
  logic [RECIP_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod;
  logic [Q_W-1:0]        q_now;
  logic [Q_W-1:0]        q_r;

  // table walk
  logic [FRAME_W:0]   rd_idx;
  logic               p_vld;
  logic [FRAME_W-1:0] p_idx;
  logic [CNT_W-1:0]   cnt, cnt_next, cnt_inc;
  logic [OWNER_W-1:0] rd_owner, own_code;
  logic               is_mine, is_free, is_last;
  tbl_rd_t            tbl_rd;
  tbl_wr_t            tbl_wr;

  logic               scan_finish;
  status_t            scan_status;
  logic [FRNUM_W-1:0] scan_frame;
  logic [CHG_W-1:0]   scan_changed;

  logic    check_done;
  status_t check_status;
  logic    alloc_short;

  status_t            res_status;
  logic [FRNUM_W-1:0] res_frame;
  logic [OFF_W-1:0]   res_off;
  logic [CHG_W-1:0]   res_changed;

  logic                rsp_valid_r;
  logic [STATUS_W-1:0] rsp_status_r;
  logic [FRNUM_W-1:0]  rsp_frame_r;
  logic [OFF_W-1:0]    rsp_off_r;
  logic [CHG_W-1:0]    rsp_changed_r;
  logic [CHG_W-1:0]    rsp_free_r;
  logic                out_free;

  pfa_frame_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd       (tbl_rd),
    .wr       (tbl_wr),
    .rd_owner (rd_owner)
  );

  assign out_free = !rsp_valid_r || rsp.ready;
  assign q_now    = prod[RECIP_SHIFT +: Q_W];
  assign own_code = OWNER_W'(id_r) + OWNER_W'(1);
  assign is_mine  = (rd_owner == own_code);
  assign is_free  = (rd_owner == '0);
  assign is_last  = (p_idx == FRAME_W'(FRAMES - 1));
  assign cnt_inc  = cnt + CNT_W'(1);

  // job checks on the captured word
  always_comb begin
    check_done   = 1'b0;
    check_status = ST_OK;
    case (op_r)
      OP_ALLOC: begin
        if (job_live[id_r]) begin
          check_done   = 1'b1;
          check_status = ST_EXISTS;
        end
      end
      OP_RECLAIM: begin
        if (!job_live[id_r]) begin
          check_done   = 1'b1;
          check_status = ST_NO_JOB;
        end
      end
      OP_TRANSLATE: begin
        if (!job_live[id_r]) begin
          check_done   = 1'b1;
          check_status = ST_NO_JOB;
        end else if (addr_r >= job_bytes[id_r]) begin
          check_done   = 1'b1;
          check_status = ST_BOUNDS;
        end
      end
      default: begin
        check_done = 1'b1;
      end
    endcase
  end

  // allocate that grants nothing: too few frames, or zero bytes
  assign alloc_short = (op_r == OP_ALLOC) &&
                       ((q_now > free_count) || (q_now == '0));

  // one table entry per cycle
  always_comb begin
    cnt_next     = cnt;
    scan_finish  = 1'b0;
    scan_status  = ST_OK;
    scan_frame   = '0;
    scan_changed = '0;
    tbl_wr.en    = 1'b0;
    tbl_wr.addr  = p_idx;
    tbl_wr.owner = '0;
    if (state == S_SCAN && p_vld) begin
      case (op_r)
        OP_ALLOC: begin
          if (is_free) begin
            tbl_wr.en    = 1'b1;
            tbl_wr.owner = own_code;
            cnt_next     = cnt_inc;
            if (cnt_inc == q_r) begin
              scan_finish  = 1'b1;
              scan_changed = CHG_W'(cnt_inc);
            end
          end
        end
        OP_RECLAIM: begin
          if (is_mine) begin
            tbl_wr.en = 1'b1;
            cnt_next  = cnt_inc;
          end
          if (is_last) begin
            scan_finish  = 1'b1;
            scan_changed = CHG_W'(is_mine ? cnt_inc : cnt);
          end
        end
        OP_TRANSLATE: begin
          if (is_mine && cnt == q_r) begin
            scan_finish = 1'b1;
            scan_frame  = FRNUM_W'(p_idx);
          end else begin
            if (is_mine) begin
              cnt_next = cnt_inc;
            end
            if (is_last) begin
              scan_finish = 1'b1;
              scan_status = ST_BOUNDS;
            end
          end
        end
        default: begin
          scan_finish = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_CHECK;
      S_CHECK: begin
        if (check_done) begin
          state_next = S_DONE;
        end else if (op_r == OP_RECLAIM) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_MUL_Q;
        end
      end
      S_MUL_Q: state_next = S_MUL_R;
      S_MUL_R: state_next = alloc_short ? S_DONE : S_SCAN;
      S_SCAN:  if (scan_finish) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready   = (state == S_IDLE);
    tbl_rd.en   = (state == S_SCAN) && (rd_idx < (FRAME_W + 1)'(FRAMES));
    tbl_rd.addr = rd_idx[FRAME_W-1:0];
    mul_a       = '0;
    mul_b       = '0;
    unique case (state)
      S_MUL_Q: begin
        mul_a = (op_r == OP_ALLOC) ? ({1'b0, bytes_r} + DIVIDEND_W'(PAGE_BYTES - 1))
                                   : DIVIDEND_W'(addr_r);
        mul_b = RECIP_W'(RECIP);
      end
      S_MUL_R: begin
        mul_a = DIVIDEND_W'(q_now);
        mul_b = RECIP_W'(PAGE_BYTES);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r    <= req.operation;
      id_r    <= req.job_id;
      bytes_r <= req.byte_count;
      addr_r  <= req.logical_address;
    end
    if (state == S_MUL_Q || state == S_MUL_R) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state == S_MUL_R) begin
      q_r <= q_now;
    end
    if (state == S_SCAN) begin
      p_idx <= rd_idx[FRAME_W-1:0];
    end
    unique case (state)
      S_CHECK: begin
        res_status  <= check_status;
        res_frame   <= '0;
        res_off     <= '0;
        res_changed <= '0;
      end
      S_MUL_R: begin
        if (op_r == OP_ALLOC && q_now > free_count) begin
          res_status <= ST_NO_FRAMES;
        end
      end
      S_SCAN: begin
        if (scan_finish) begin
          res_status  <= scan_status;
          res_frame   <= scan_frame;
          res_changed <= scan_changed;
          if (op_r == OP_TRANSLATE && scan_status == ST_OK) begin
            res_off <= OFF_W'(addr_r - prod[ADDR_W-1:0]);
          end
        end
      end
      default: ;
    endcase
  end

  // walk counters
  always_ff @(posedge clk) begin
    if (rst || state != S_SCAN) begin
      rd_idx <= '0;
      p_vld  <= 1'b0;
      cnt    <= '0;
    end else begin
      p_vld <= tbl_rd.en;
      cnt   <= cnt_next;
      if (tbl_rd.en) begin
        rd_idx <= rd_idx + (FRAME_W + 1)'(1);
      end
    end
  end

  // job records and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      job_live   <= '0;
      free_count <= CNT_W'(FRAMES);
      for (int j = 0; j < JOBS; j++) begin
        job_bytes[j] <= '0;
      end
    end else begin
      if (state == S_MUL_R && op_r == OP_ALLOC && q_now == '0) begin
        job_live[id_r]  <= 1'b1;
        job_bytes[id_r] <= bytes_r;
      end
      if (state == S_SCAN && scan_finish) begin
        if (op_r == OP_ALLOC) begin
          job_live[id_r]  <= 1'b1;
          job_bytes[id_r] <= bytes_r;
          free_count      <= free_count - q_r;
        end else if (op_r == OP_RECLAIM) begin
          job_live[id_r]  <= 1'b0;
          job_bytes[id_r] <= '0;
          free_count      <= free_count + CNT_W'(scan_changed);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_r <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid_r <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_r <= 1'b0;
    end
    if (state == S_DONE && out_free) begin
      rsp_status_r  <= res_status;
      rsp_frame_r   <= res_frame;
      rsp_off_r     <= res_off;
      rsp_changed_r <= res_changed;
      rsp_free_r    <= CHG_W'(free_count);
    end
  end

  assign rsp.valid          = rsp_valid_r;
  assign rsp.status         = rsp_status_r;
  assign rsp.frame_number   = rsp_frame_r;
  assign rsp.page_offset    = rsp_off_r;
  assign rsp.frames_changed = rsp_changed_r;
  assign rsp.free_frames    = rsp_free_r;

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(FRAMES))
    else $error("free frame count above table size");

  a_wr_in_scan: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> state == S_SCAN)
    else $error("frame table written outside a walk");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && op_r == OP_ALLOC) |-> cnt < q_r)
    else $error("allocate granted past its need");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (rsp_valid_r && state == S_IDLE))
    else $error("result not loaded into output register");

endmodule

// File: verif/paged_frame_allocator_top_tb.sv
`timescale 1ns / 1ps

module paged_frame_allocator_top_tb;
  import pfa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1420;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 140;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 550;
  localparam int HOLD_AT      = 800;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [JOB_W-1:0]   id;
    logic [BYTES_W-1:0] nbytes;
    logic [ADDR_W-1:0]  addr;
  } request_t;

  typedef struct {
    status_t            status;
    logic [FRNUM_W-1:0] frame;
    logic [OFF_W-1:0]   offset;
    logic [CHG_W-1:0]   changed;
    logic [CHG_W-1:0]   remaining;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfa_req_if req ();
  pfa_rsp_if rsp ();

  paged_frame_allocator_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  request_t pending_q[$];
  outcome_t expected_q[$];

  // allocator state as predicted from accepted words
  logic [OWNER_W-1:0] frame_holder[FRAMES];
  logic [BYTES_W-1:0] job_size[JOBS];
  bit                 job_present[JOBS];
  int                 frames_free;

  // coarse view used only to steer stimulus toward free or live jobs and in-range addresses
  bit plan_live[JOBS];
  int plan_size[JOBS];
  int plan_free;

  int words_in;
  int results_seen;
  int errors;
  int cycles;
  int status_tally[5];
  int hold_left;
  bit hold_done;
  wire quiet = (words_in >= QUIET_FROM) && (words_in < QUIET_TO);

  task automatic apply_request(input request_t w);
    outcome_t r;
    int need;
    int got;
    int seen;
    int tag;
    r = '{ST_OK, '0, '0, '0, '0};
    tag = w.id + 1;
    if (w.op == OP_UNUSED) begin
      // ignored word
    end else if (w.id >= JOBS) begin
      r.status = ST_NO_JOB;
    end else if (w.op == OP_ALLOC) begin
      need = (w.nbytes + PAGE_BYTES - 1) / PAGE_BYTES;
      if (job_present[w.id]) begin
        r.status = ST_EXISTS;
      end else if (need > frames_free) begin
        r.status = ST_NO_FRAMES;
      end else begin
        got = 0;
        for (int f = 0; f < FRAMES && got < need; f++) begin
          if (frame_holder[f] == 0) begin
            frame_holder[f] = OWNER_W'(tag);
            got++;
          end
        end
        frames_free -= got;
        job_present[w.id] = 1'b1;
        job_size[w.id] = w.nbytes;
        r.changed = CHG_W'(got);
      end
    end else if (!job_present[w.id]) begin
      r.status = ST_NO_JOB;
    end else if (w.op == OP_RECLAIM) begin
      got = 0;
      for (int f = 0; f < FRAMES; f++) begin
        if (frame_holder[f] == tag) begin
          frame_holder[f] = '0;
          got++;
        end
      end
      frames_free += got;
      job_present[w.id] = 1'b0;
      job_size[w.id] = '0;
      r.changed = CHG_W'(got);
    end else if (w.addr >= job_size[w.id]) begin
      r.status = ST_BOUNDS;
    end else begin
      r.status = ST_BOUNDS;
      seen = 0;
      for (int f = 0; f < FRAMES; f++) begin
        if (frame_holder[f] == tag) begin
          if (seen == w.addr / PAGE_BYTES) begin
            r.status = ST_OK;
            r.frame = FRNUM_W'(f);
            r.offset = OFF_W'(w.addr % PAGE_BYTES);
            break;
          end
          seen++;
        end
      end
    end
    r.remaining = CHG_W'(frames_free);
    expected_q = {expected_q, r};
  endtask

  task automatic queue_word(input logic [OP_W-1:0] op, input int id, input int nbytes,
                            input int addr);
    request_t w;
    int need;
    w.op = op;
    w.id = JOB_W'(id);
    w.nbytes = BYTES_W'(nbytes);
    w.addr = ADDR_W'(addr);
    need = (w.nbytes + PAGE_BYTES - 1) / PAGE_BYTES;
    pending_q = {pending_q, w};
    if (op == OP_ALLOC && !plan_live[w.id] && need <= plan_free) begin
      plan_live[w.id] = 1'b1;
      plan_size[w.id] = w.nbytes;
      plan_free -= need;
    end else if (op == OP_RECLAIM && plan_live[w.id]) begin
      plan_live[w.id] = 1'b0;
      plan_free += (plan_size[w.id] + PAGE_BYTES - 1) / PAGE_BYTES;
    end
  endtask

  function automatic int pick_job(input bit want_live);
    int cands[$];
    for (int j = 0; j < JOBS; j++) begin
      if (plan_live[j] == want_live) cands = {cands, j};
    end
    if (cands.size() == 0) return $urandom_range(0, JOBS - 1);
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      words_in <= 0;
    end else begin
      if (req.valid && req.ready) begin
        apply_request('{req.operation, req.job_id, req.byte_count, req.logical_address});
        words_in <= words_in + 1;
      end
      if (!req.valid || req.ready) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
          req.valid           <= 1'b1;
          req.operation       <= pending_q[0].op;
          req.job_id          <= pending_q[0].id;
          req.byte_count      <= pending_q[0].nbytes;
          req.logical_address <= pending_q[0].addr;
          void'(pending_q.pop_front());
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      rsp.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp.ready <= quiet || ($urandom_range(0, 99) >= 16);
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result word with no request outstanding");
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("frame_number", want.frame, rsp.frame_number);
        check_field("page_offset", want.offset, rsp.page_offset);
        check_field("frames_changed", want.changed, rsp.frames_changed);
        check_field("free_frames", want.remaining, rsp.free_frames);
        status_tally[int'(want.status)]++;
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout: %0d of %0d results outstanding", expected_q.size(), pending_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int pick;
    int roll;
    int id;
    int nbytes;
    int addr;

    req.valid = 1'b0;
    req.operation = '0;
    req.job_id = '0;
    req.byte_count = '0;
    req.logical_address = '0;
    rsp.ready = 1'b0;
    results_seen = 0;
    errors = 0;
    frames_free = FRAMES;
    plan_free = FRAMES;
    for (int f = 0; f < FRAMES; f++) frame_holder[f] = '0;
    for (int j = 0; j < JOBS; j++) begin
      job_size[j] = '0;
      job_present[j] = 1'b0;
      plan_live[j] = 1'b0;
      plan_size[j] = 0;
    end
    for (int s = 0; s < 5; s++) status_tally[s] = 0;

    // directed: zero-byte job, exists, full table, gaps, bounds, unused op
    queue_word(OP_ALLOC, 0, 0, 0);
    queue_word(OP_TRANSLATE, 0, 0, 0);
    queue_word(OP_RECLAIM, 0, 0, 0);
    queue_word(OP_RECLAIM, 0, 0, 0);
    queue_word(OP_ALLOC, 1, 1, 0);
    queue_word(OP_ALLOC, 1, 5000, 0);
    queue_word(OP_TRANSLATE, 1, 0, 0);
    queue_word(OP_TRANSLATE, 1, 0, 1);
    queue_word(OP_ALLOC, 2, 128000, 0);
    queue_word(OP_ALLOC, 2, 127000, 0);
    queue_word(OP_ALLOC, 3, 0, 0);
    queue_word(OP_ALLOC, 4, 1, 0);
    queue_word(OP_TRANSLATE, 2, 0, 126999);
    queue_word(OP_TRANSLATE, 2, 0, 1000);
    queue_word(OP_RECLAIM, 1, 0, 0);
    queue_word(OP_ALLOC, 5, 1000, 0);
    queue_word(OP_RECLAIM, 2, 0, 0);
    queue_word(OP_ALLOC, 6, 3500, 0);
    queue_word(OP_TRANSLATE, 6, 0, 3499);
    queue_word(OP_TRANSLATE, 7, 131071, 131071);
    queue_word(OP_UNUSED, 15, 131071, 131071);
    queue_word(OP_ALLOC, 15, 131071, 0);
    queue_word(OP_RECLAIM, 5, 0, 0);
    queue_word(OP_RECLAIM, 6, 0, 0);
    queue_word(OP_RECLAIM, 3, 0, 0);
    queue_word(OP_ALLOC, 15, 128000, 0);
    queue_word(OP_TRANSLATE, 15, 0, 127999);
    queue_word(OP_RECLAIM, 15, 0, 0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      roll = $urandom_range(0, 99);
      if (pick < 30) begin
        id = (roll < 80) ? pick_job(1'b0) : $urandom_range(0, JOBS - 1);
        roll = $urandom_range(0, 99);
        if (roll < 70) nbytes = $urandom_range(0, 12000);
        else if (roll < 90) nbytes = $urandom_range(0, 60000);
        else nbytes = $urandom & 32'h1FFFF;
        queue_word(OP_ALLOC, id, nbytes, 0);
      end else if (pick < 50) begin
        id = (roll < 85) ? pick_job(1'b1) : $urandom_range(0, JOBS - 1);
        queue_word(OP_RECLAIM, id, $urandom & 32'h1FFFF, $urandom & 32'h1FFFF);
      end else if (pick < 95) begin
        id = (roll < 85) ? pick_job(1'b1) : $urandom_range(0, JOBS - 1);
        roll = $urandom_range(0, 99);
        if (!plan_live[id] || plan_size[id] == 0 || roll >= 95) addr = $urandom & 32'h1FFFF;
        else if (roll < 75) addr = $urandom_range(0, plan_size[id] - 1);
        else if (roll < 88) addr = plan_size[id] - 1;
        else addr = plan_size[id];
        queue_word(OP_TRANSLATE, id, $urandom & 32'h1FFFF, addr);
      end else begin
        queue_word(OP_UNUSED, $urandom_range(0, JOBS - 1), $urandom & 32'h1FFFF,
                   $urandom & 32'h1FFFF);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || req.valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d request words, %0d result words checked, %0d cycles",
             words_in, results_seen, cycles);
    $display("ok %0d, short of frames %0d, job missing %0d, out of bounds %0d, exists %0d",
             status_tally[ST_OK], status_tally[ST_NO_FRAMES], status_tally[ST_NO_JOB],
             status_tally[ST_BOUNDS], status_tally[ST_EXISTS]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: paged_frame_allocator_top.f
sv/pfa_pkg.sv
sv/pfa_req_if.sv
sv/pfa_rsp_if.sv
sv/pfa_frame_table.sv
sv/paged_frame_allocator_top.sv
verif/paged_frame_allocator_top_tb.sv
